// File: rtl/sensor_thp_compensation_core_defines.svh
// Assertion macros for the sensor compensation core.
// Included by the top level; no dependencies.
`ifndef SENSOR_THP_COMPENSATION_CORE_DEFINES_SVH
`define SENSOR_THP_COMPENSATION_CORE_DEFINES_SVH
`ifndef SYNTH
`define STC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stc assertion failed");
`define STC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stc assertion failed");
`else
`define STC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/stc_pkg.sv
// Shared types, constants and a wrap-around multiply helper for the compensation core.
// No dependencies.
package stc_pkg;

   localparam int unsigned FRONT_STAGES = 12;
   localparam int unsigned DIV_STAGES   = 34;

   localparam logic signed [31:0] PRS_TF_OFS = 32'sd64000;
   localparam logic signed [31:0] HUM_TF_OFS = 32'sd76800;
   localparam logic signed [35:0] PRS_BASE   = 36'sd1048576;
   localparam logic signed [35:0] PRS_SCALE  = 36'sd3125;
   localparam logic signed [35:0] PRS_SPLIT  = 36'sh080000000;
   localparam logic signed [31:0] PRS_P1_OFS = 32'sd32768;
   localparam logic signed [31:0] HUM_CLAMP  = 32'sd419430400;
   localparam logic signed [31:0] HUM_H_OFS  = 32'sd2097152;
   localparam logic signed [31:0] HUM_S_OFS  = 32'sd32768;
   localparam logic signed [31:0] HUM_G_RND  = 32'sd16384;
   localparam logic signed [31:0] HUM_H_RND  = 32'sd8192;
   localparam logic signed [31:0] TMP_RND    = 32'sd128;
   localparam logic [16:0]        HUM_OUT_MAX = 17'd102400;

   typedef enum logic [2:0] {
      REG_CAL_T  = 3'd0,
      REG_CAL_PA = 3'd1,
      REG_CAL_PB = 3'd2,
      REG_CAL_PC = 3'd3,
      REG_CAL_HA = 3'd4,
      REG_CAL_HB = 3'd5
   } stc_reg_type;

   typedef struct packed {
      logic signed [31:0] t1, t2, t3;
      logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [31:0] h1, h2, h3, h4, h5, h6;
   } stc_cal_type;

   typedef struct packed {
      logic signed [23:0] temp;
      logic [16:0]        hum;
      logic               div_zero;
      logic               neg;
      logic               dbl;
      logic [33:0]        mag;
      logic [31:0]        div;
   } stc_item_type;

   function automatic logic signed [31:0] wmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return a * b;
   endfunction

endpackage

// File: rtl/stc_front.sv
// Front pipeline: fine temperature, temperature, humidity and pressure divisor and dividend set-up.
// Depends on stc_pkg.
module stc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [19:0]           raw_temperature,
   input  logic [19:0]           raw_pressure,
   input  logic [15:0]           raw_humidity,
   input  stc_pkg::stc_cal_type  cal,
   output logic                  out_valid,
   output stc_pkg::stc_item_type out_item,
   input  logic                  out_ready
);
   import stc_pkg::*;

   logic [FRONT_STAGES-1:0] vld_ff;
   logic en;

   logic [19:0]        rp_ff [1:8];
   logic [15:0]        rh_ff [1:4];
   logic signed [23:0] tc_ff [4:9];
   logic signed [31:0] a1_ff, dd1_ff, v1_ff, v2p_ff, tf_ff, pa_ff, hx_ff;
   logic signed [31:0] bb_ff, ap5_ff, f05_ff, g05_ff, hm_ff, hs_ff;
   logic signed [31:0] b6_ff, e6_ff, ap6_ff, f6_ff, g6_ff, hh6_ff, sv6_ff;
   logic signed [31:0] b7_ff, a7_ff, g7_ff, h7_ff, b8_ff, a8_ff, g8_ff, h8_ff;
   logic signed [35:0] pm9_ff;
   logic [31:0]        div9_ff;
   logic               dz9_ff;
   logic signed [31:0] x9_ff, x10_ff, s10_ff, x11_ff, s11_ff;
   stc_item_type       itm10_ff, itm11_ff, itm12_ff;

   logic signed [31:0] rt_w, u_w, d_w, temp_w, qa_w, rhs_w, h4s_w, sq_w, xs_w, hc_w;
   logic signed [35:0] pb_w, two_w;
   logic               sel_w, neg_w;
   logic [33:0]        mag_w;
   stc_item_type       itm_w;

   assign en        = !vld_ff[FRONT_STAGES-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_item  = itm12_ff;

   always_comb begin
      rt_w   = $signed({12'd0, raw_temperature});
      u_w    = (rt_w >>> 3) - (cal.t1 <<< 1);
      d_w    = (rt_w >>> 4) - cal.t1;
      temp_w = (wmul(tf_ff, 32'sd5) + TMP_RND) >>> 8;
      qa_w   = pa_ff >>> 2;
      rhs_w  = $signed({2'd0, rh_ff[4], 14'd0});
      h4s_w  = $signed({cal.h4[11:0], 20'd0});
      pb_w   = PRS_BASE - $signed({16'd0, rp_ff[8]}) - 36'(b8_ff >>> 12);
      two_w  = pm9_ff <<< 1;
      sel_w  = pm9_ff < PRS_SPLIT;
      neg_w  = sel_w && two_w[35];
      if (!sel_w) begin
         mag_w = pm9_ff[33:0];
      end else if (neg_w) begin
         mag_w = 34'(-two_w);
      end else begin
         mag_w = two_w[33:0];
      end
      sq_w = x9_ff >>> 15;
      xs_w = x11_ff - s11_ff;
      if (xs_w < 0) begin
         hc_w = '0;
      end else if (xs_w > HUM_CLAMP) begin
         hc_w = HUM_CLAMP;
      end else begin
         hc_w = xs_w;
      end
      itm_w     = itm11_ff;
      itm_w.hum = hc_w[28:12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[1] <= raw_pressure;
         for (int k = 2; k <= 8; k++) rp_ff[k] <= rp_ff[k-1];
         rh_ff[1] <= raw_humidity;
         for (int k = 2; k <= 4; k++) rh_ff[k] <= rh_ff[k-1];
         tc_ff[4] <= temp_w[23:0];
         for (int k = 5; k <= 9; k++) tc_ff[k] <= tc_ff[k-1];

         a1_ff  <= wmul(u_w, cal.t2);
         dd1_ff <= wmul(d_w, d_w);
         v1_ff  <= a1_ff >>> 11;
         v2p_ff <= wmul(dd1_ff >>> 12, cal.t3);
         tf_ff  <= v1_ff + (v2p_ff >>> 14);
         pa_ff  <= (tf_ff >>> 1) - PRS_TF_OFS;
         hx_ff  <= tf_ff - HUM_TF_OFS;

         bb_ff  <= wmul(qa_w, qa_w);
         ap5_ff <= wmul(pa_ff, cal.p5);
         f05_ff <= wmul(cal.p2, pa_ff);
         g05_ff <= rhs_w - h4s_w - wmul(cal.h5, hx_ff);
         hm_ff  <= wmul(hx_ff, cal.h6);
         hs_ff  <= wmul(hx_ff, cal.h3);

         b6_ff  <= wmul(bb_ff >>> 11, cal.p6);
         e6_ff  <= wmul(cal.p3, bb_ff >>> 13);
         ap6_ff <= ap5_ff;
         f6_ff  <= f05_ff >>> 1;
         g6_ff  <= (g05_ff + HUM_G_RND) >>> 15;
         hh6_ff <= hm_ff >>> 10;
         sv6_ff <= (hs_ff >>> 11) + HUM_S_OFS;

         b7_ff  <= ((b6_ff + (ap6_ff <<< 1)) >>> 2) + (cal.p4 <<< 16);
         a7_ff  <= ((e6_ff >>> 3) + f6_ff) >>> 18;
         g7_ff  <= g6_ff;
         h7_ff  <= (wmul(hh6_ff, sv6_ff) >>> 10) + HUM_H_OFS;

         b8_ff  <= b7_ff;
         a8_ff  <= wmul(a7_ff + PRS_P1_OFS, cal.p1) >>> 15;
         g8_ff  <= g7_ff;
         h8_ff  <= (wmul(h7_ff, cal.h2) + HUM_H_RND) >>> 14;

         pm9_ff  <= pb_w * PRS_SCALE;
         div9_ff <= a8_ff;
         dz9_ff  <= (a8_ff == 32'sd0);
         x9_ff   <= wmul(g8_ff, h8_ff);

         itm10_ff.temp     <= tc_ff[9];
         itm10_ff.hum      <= '0;
         itm10_ff.div_zero <= dz9_ff;
         itm10_ff.neg      <= neg_w;
         itm10_ff.dbl      <= !sel_w;
         itm10_ff.mag      <= mag_w;
         itm10_ff.div      <= div9_ff;
         x10_ff <= x9_ff;
         s10_ff <= wmul(sq_w, sq_w) >>> 7;

         itm11_ff <= itm10_ff;
         x11_ff   <= x10_ff;
         s11_ff   <= wmul(s10_ff, cal.h1) >>> 4;

         itm12_ff <= itm_w;
      end
   end

endmodule

// File: rtl/stc_queue.sv
// Short first-in first-out queue between the front and back pipelines.
// Depends on stc_pkg.
module stc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  stc_pkg::stc_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output stc_pkg::stc_item_type head_item
);
   import stc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   stc_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CNT_W'(1);
            2'b01:   count_ff <= count_ff - CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: rtl/stc_back.sv
// Back pipeline: bit-per-stage pressure divider, pressure correction, result register.
// Depends on stc_pkg.
module stc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  stc_pkg::stc_item_type in_item,
   output logic                  pop,
   input  stc_pkg::stc_cal_type  cal,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [23:0]    temperature_centi,
   output logic [31:0]           pressure_pa,
   output logic                  pressure_div_zero,
   output logic [16:0]           humidity_q10
);
   import stc_pkg::*;

   logic                  en;
   logic [DIV_STAGES-1:0] dvld_ff;
   logic [31:0]           rem_ff  [DIV_STAGES];
   logic [33:0]           num_ff  [DIV_STAGES];
   stc_item_type          ditm_ff [DIV_STAGES];

   logic [2:0]         pvld_ff;
   logic               out_vld_ff;
   logic signed [35:0] pq_ff;
   stc_item_type       pitm_ff [3];
   logic signed [31:0] e1_ff, f1_ff, e2_ff, f2_ff;
   logic [31:0]        pl1_ff, pl2_ff;
   logic [33:0]        q_w;
   logic signed [31:0] adj_w;

   assign en        = !out_vld_ff || out_ready;
   assign pop       = en && in_valid;
   assign out_valid = out_vld_ff;

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      logic [31:0]  src_rem;
      logic [33:0]  src_num;
      stc_item_type src_itm;
      logic [32:0]  trial;
      logic         ge;
      if (i == 0) begin : g_first
         assign src_rem = '0;
         assign src_num = in_item.mag;
         assign src_itm = in_item;
      end else begin : g_next
         assign src_rem = rem_ff[i-1];
         assign src_num = num_ff[i-1];
         assign src_itm = ditm_ff[i-1];
      end
      assign trial = {src_rem, src_num[33]};
      assign ge    = trial >= {1'b0, src_itm.div};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? 32'(trial - {1'b0, src_itm.div}) : trial[31:0];
            num_ff[i]  <= {src_num[32:0], ge};
            ditm_ff[i] <= src_itm;
         end
      end
   end

   assign q_w   = num_ff[DIV_STAGES-1];
   assign adj_w = ((e2_ff >>> 12) + f2_ff + cal.p7) >>> 4;

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff    <= '0;
         pvld_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         dvld_ff    <= {dvld_ff[DIV_STAGES-2:0], in_valid};
         pvld_ff    <= {pvld_ff[1:0], dvld_ff[DIV_STAGES-1]};
         out_vld_ff <= pvld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (ditm_ff[DIV_STAGES-1].dbl) begin
            pq_ff <= $signed({1'b0, q_w, 1'b0});
         end else if (ditm_ff[DIV_STAGES-1].neg) begin
            pq_ff <= -$signed({2'b0, q_w});
         end else begin
            pq_ff <= $signed({2'b0, q_w});
         end
         pitm_ff[0] <= ditm_ff[DIV_STAGES-1];

         e1_ff      <= wmul($signed(pq_ff[34:3]), $signed(pq_ff[34:3]));
         f1_ff      <= wmul($signed(pq_ff[33:2]), cal.p8);
         pl1_ff     <= pq_ff[31:0];
         pitm_ff[1] <= pitm_ff[0];

         e2_ff      <= wmul(cal.p9, e1_ff >>> 13);
         f2_ff      <= f1_ff >>> 13;
         pl2_ff     <= pl1_ff;
         pitm_ff[2] <= pitm_ff[1];

         temperature_centi <= pitm_ff[2].temp;
         humidity_q10      <= pitm_ff[2].hum;
         pressure_div_zero <= pitm_ff[2].div_zero;
         pressure_pa       <= pitm_ff[2].div_zero ? 32'd0 : pl2_ff + $unsigned(adj_w);
      end
   end

endmodule

// File: rtl/sensor_thp_compensation_core.sv
// Throughput: one reading set per cycle when nothing stalls; the 34-stage pressure divider and
// the twelve-stage front pipeline each advance only while back-pressure does not hold them.
// Reset (synchronous, active high) clears all calibration registers to zero and
// empties every pipeline stage and the queue.
`include "sensor_thp_compensation_core_defines.svh"
module sensor_thp_compensation_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // raw_temperature, raw_pressure, raw_humidity
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // temperature_centi, pressure_pa,
                                    // pressure_div_zero, humidity_q10, zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [47:0] csr_wdata
);
   import stc_pkg::*;

   logic [47:0] cal_t_ff, cal_pa_ff, cal_pb_ff, cal_pc_ff;
   logic [39:0] cal_ha_ff;
   logic [23:0] cal_hb_ff;
   stc_cal_type cal;

   logic               f_vld, q_full, q_push, q_pop, q_vld;
   stc_item_type       f_item, q_item;
   logic signed [23:0] temp_o;
   logic [31:0]        press_o;
   logic               dz_o;
   logic [16:0]        hum_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_pa_ff <= '0;
         cal_pb_ff <= '0;
         cal_pc_ff <= '0;
         cal_ha_ff <= '0;
         cal_hb_ff <= '0;
      end else if (csr_we) begin
         unique case (stc_reg_type'(csr_addr))
            REG_CAL_T:  cal_t_ff  <= csr_wdata;
            REG_CAL_PA: cal_pa_ff <= csr_wdata;
            REG_CAL_PB: cal_pb_ff <= csr_wdata;
            REG_CAL_PC: cal_pc_ff <= csr_wdata;
            REG_CAL_HA: cal_ha_ff <= csr_wdata[39:0];
            REG_CAL_HB: cal_hb_ff <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = $signed({16'd0, cal_t_ff[15:0]});
      cal.t2 = $signed({{16{cal_t_ff[31]}}, cal_t_ff[31:16]});
      cal.t3 = $signed({{16{cal_t_ff[47]}}, cal_t_ff[47:32]});
      cal.p1 = $signed({16'd0, cal_pa_ff[15:0]});
      cal.p2 = $signed({{16{cal_pa_ff[31]}}, cal_pa_ff[31:16]});
      cal.p3 = $signed({{16{cal_pa_ff[47]}}, cal_pa_ff[47:32]});
      cal.p4 = $signed({{16{cal_pb_ff[15]}}, cal_pb_ff[15:0]});
      cal.p5 = $signed({{16{cal_pb_ff[31]}}, cal_pb_ff[31:16]});
      cal.p6 = $signed({{16{cal_pb_ff[47]}}, cal_pb_ff[47:32]});
      cal.p7 = $signed({{16{cal_pc_ff[15]}}, cal_pc_ff[15:0]});
      cal.p8 = $signed({{16{cal_pc_ff[31]}}, cal_pc_ff[31:16]});
      cal.p9 = $signed({{16{cal_pc_ff[47]}}, cal_pc_ff[47:32]});
      cal.h1 = $signed({24'd0, cal_ha_ff[7:0]});
      cal.h2 = $signed({{16{cal_ha_ff[23]}}, cal_ha_ff[23:8]});
      cal.h3 = $signed({24'd0, cal_ha_ff[31:24]});
      cal.h6 = $signed({{24{cal_ha_ff[39]}}, cal_ha_ff[39:32]});
      cal.h4 = $signed({{20{cal_hb_ff[11]}}, cal_hb_ff[11:0]});
      cal.h5 = $signed({{20{cal_hb_ff[23]}}, cal_hb_ff[23:12]});
   end

   stc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .raw_temperature (req_tdata[19:0]),
      .raw_pressure    (req_tdata[39:20]),
      .raw_humidity    (req_tdata[55:40]),
      .cal             (cal),
      .out_valid       (f_vld),
      .out_item        (f_item),
      .out_ready       (!q_full)
   );

   assign q_push = f_vld && !q_full;

   stc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (f_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_vld),
      .head_item  (q_item)
   );

   stc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (q_vld),
      .in_item           (q_item),
      .pop               (q_pop),
      .cal               (cal),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .temperature_centi (temp_o),
      .pressure_pa       (press_o),
      .pressure_div_zero (dz_o),
      .humidity_q10      (hum_o)
   );

   assign rsp_tdata = {6'd0, hum_o, dz_o, press_o, temp_o};

   `STC_ASSERT_IMP(a_divzero_press, clock, reset, rsp_tvalid && rsp_tdata[56], rsp_tdata[55:24] == 32'd0)
   `STC_ASSERT_IMP(a_hum_range, clock, reset, rsp_tvalid, rsp_tdata[73:57] <= HUM_OUT_MAX)
   `STC_ASSERT_IMP(a_stall_cause, clock, reset, !req_tready, f_vld && q_full)
   `STC_ASSERT_NXT(a_queue_hold, clock, reset, q_full && !q_pop, q_full)

endmodule

// File: sim/sensor_thp_compensation_core_tb.sv
// Testbench for the temperature, pressure and humidity compensation core.
// Predicts each result from raw readings and calibration, checks every field.
// Depends on stc_pkg and the sensor_thp_compensation_core RTL.
`timescale 1ns / 100ps
module sensor_thp_compensation_core_tb;
   import stc_pkg::*;

   typedef struct packed {
      logic [16:0]        hum;
      logic               dz;
      logic [31:0]        press;
      logic signed [23:0] temp;
   } comp_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [47:0] csr_wdata = '0;

   logic [47:0]      cal_regs [0:5];
   logic [55:0]      pending_readings [$];
   comp_reading_type expected_readings [$];
   int               n_errors = 0;
   int               cycle_count = 0;
   bit               quiet_req = 1'b0;
   bit               quiet_rsp = 1'b0;
   bit               req_taken = 1'b0;

   sensor_thp_compensation_core DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] sfld(logic [47:0] r, int lo, int bits);
      logic [47:0] v;
      v = (r >> lo) & ((48'd1 << bits) - 1);
      if (v[bits-1]) return 32'(v) - (32'sd1 <<< bits);
      return 32'(v);
   endfunction

   function automatic longint trunc_div(longint a, longint b);
      longint q;
      q = (a < 0 ? -a : a) / b;
      return (a < 0) ? -q : q;
   endfunction

   function automatic comp_reading_type compensate(logic [55:0] raw);
      int t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
      int rt, rp, rh, v1, v2, d, tfine, a, b, q, e, f, x, g, h, s;
      longint p, dv;
      comp_reading_type r;
      rt = int'(raw[19:0]); rp = int'(raw[39:20]); rh = int'(raw[55:40]);
      t1 = int'(cal_regs[REG_CAL_T][15:0]);
      t2 = sfld(cal_regs[REG_CAL_T], 16, 16); t3 = sfld(cal_regs[REG_CAL_T], 32, 16);
      p1 = int'(cal_regs[REG_CAL_PA][15:0]);
      p2 = sfld(cal_regs[REG_CAL_PA], 16, 16); p3 = sfld(cal_regs[REG_CAL_PA], 32, 16);
      p4 = sfld(cal_regs[REG_CAL_PB], 0, 16); p5 = sfld(cal_regs[REG_CAL_PB], 16, 16);
      p6 = sfld(cal_regs[REG_CAL_PB], 32, 16);
      p7 = sfld(cal_regs[REG_CAL_PC], 0, 16); p8 = sfld(cal_regs[REG_CAL_PC], 16, 16);
      p9 = sfld(cal_regs[REG_CAL_PC], 32, 16);
      h1 = int'(cal_regs[REG_CAL_HA][7:0]); h2 = sfld(cal_regs[REG_CAL_HA], 8, 16);
      h3 = int'(cal_regs[REG_CAL_HA][31:24]); h6 = sfld(cal_regs[REG_CAL_HA], 32, 8);
      h4 = sfld(cal_regs[REG_CAL_HB], 0, 12); h5 = sfld(cal_regs[REG_CAL_HB], 12, 12);
      v1 = ((rt >>> 3) - (t1 <<< 1)) * t2 >>> 11;
      d = (rt >>> 4) - t1;
      v2 = ((d * d) >>> 12) * t3 >>> 14;
      tfine = v1 + v2;
      r.temp = 24'((tfine * 5 + 128) >>> 8);
      a = (tfine >>> 1) - 64000;
      b = a >>> 2;
      b = (b * b) >>> 11;
      b = b * p6 + ((a * p5) <<< 1);
      b = (b >>> 2) + (p4 <<< 16);
      q = a >>> 2;
      q = (q * q) >>> 13;
      e = (p3 * q) >>> 3;
      f = (p2 * a) >>> 1;
      a = (e + f) >>> 18;
      a = ((32768 + a) * p1) >>> 15;
      r.press = '0; r.dz = 1'b0;
      if (a == 0) r.dz = 1'b1;
      else begin
         dv = longint'(unsigned'(a));
         p = (64'sd1048576 - rp - (b >>> 12)) * 3125;
         if (p < 64'sd2147483648) p = trunc_div(p * 2, dv);
         else p = trunc_div(p, dv) * 2;
         e = int'(p >>> 3);
         e = (e * e) >>> 13;
         e = (p9 * e) >>> 12;
         f = int'(p >>> 2);
         f = (f * p8) >>> 13;
         p = p + ((e + f + p7) >>> 4);
         r.press = p[31:0];
      end
      x = tfine - 76800;
      g = ((rh <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
      h = (x * h6) >>> 10;
      s = ((x * h3) >>> 11) + 32768;
      h = (((((h * s) >>> 10) + 2097152) * h2) + 8192) >>> 14;
      x = g * h;
      s = x >>> 15;
      s = ((s * s) >>> 7) * h1 >>> 4;
      x = x - s;
      if (x < 0) x = 0;
      if (x > 419430400) x = 419430400;
      r.hum = 17'(x >>> 12);
      return r;
   endfunction

   task automatic write_cal(stc_reg_type idx, logic [47:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      cal_regs[idx] = (idx == REG_CAL_HA) ? (val & 48'hFF_FFFF_FFFF) :
                      (idx == REG_CAL_HB) ? (val & 48'hFF_FFFF) : val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained;
      while (pending_readings.size() != 0 || expected_readings.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [55:0] rand_reading();
      return {16'($urandom), 20'($urandom), 20'($urandom)};
   endfunction

   // typical calibration with random jitter, so pressure and humidity stay meaningful
   task automatic load_typical_cal();
      write_cal(REG_CAL_T, {16'($urandom_range(0, 100)), 16'($urandom_range(26000, 27000)),
                            16'($urandom_range(27000, 28500))});
      write_cal(REG_CAL_PA, {16'($urandom_range(0, 4000)),
                             16'(-$urandom_range(10000, 11000)),
                             16'($urandom_range(35000, 37500))});
      write_cal(REG_CAL_PB, {16'(-$urandom_range(0, 20)), 16'($urandom_range(0, 300)),
                             16'($urandom_range(6000, 8000))});
      write_cal(REG_CAL_PC, {16'($urandom_range(4000, 5000)), 16'(-$urandom_range(10000, 12000)),
                             16'($urandom_range(0, 20))});
      write_cal(REG_CAL_HA, {8'($urandom_range(0, 40)), 8'($urandom_range(0, 10)),
                             16'($urandom_range(300, 400)), 8'($urandom_range(50, 100))});
      write_cal(REG_CAL_HB, {12'($urandom_range(0, 100)), 12'($urandom_range(200, 400))});
   endtask

   // a beat is replaced only once the last rising edge took it
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken || !req_tvalid) begin
            if (pending_readings.size() != 0 &&
                (quiet_req || $urandom_range(0, 99) >= 31)) begin
               req_tdata <= pending_readings.pop_front();
               req_tvalid <= 1'b1;
            end else req_tvalid <= 1'b0;
         end
         rsp_tready <= quiet_rsp || ($urandom_range(0, 99) >= 31);
      end
   end

   // predict on every accepted request beat, check on every accepted result beat
   always @(posedge clock) begin
      comp_reading_type got, want;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_readings.push_back(compensate(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[73:0];
         if (expected_readings.size() == 0) begin
            $error("unexpected result beat %h", rsp_tdata);
            n_errors++;
         end else begin
            want = expected_readings.pop_front();
            if (got.temp !== want.temp) begin
               $error("temperature_centi exp %0d got %0d", want.temp, got.temp);
               n_errors++;
            end
            if (got.press !== want.press) begin
               $error("pressure_pa exp %0d got %0d", want.press, got.press);
               n_errors++;
            end
            if (got.dz !== want.dz) begin
               $error("pressure_div_zero exp %0d got %0d", want.dz, got.dz);
               n_errors++;
            end
            if (got.hum !== want.hum) begin
               $error("humidity_q10 exp %0d got %0d", want.hum, got.hum);
               n_errors++;
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 6; i++) cal_regs[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // reset calibration: every divisor zero
      pending_readings.push_back('0);
      pending_readings.push_back('1);
      wait_drained();
      load_typical_cal();
      pending_readings.push_back({16'd0, 20'd0, 20'd0});
      pending_readings.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
      pending_readings.push_back({16'd0, 20'hFFFFF, 20'd0});
      pending_readings.push_back({16'hFFFF, 20'd0, 20'hFFFFF});
      pending_readings.push_back({16'd30000, 20'd415148, 20'd519888});
      pending_readings.push_back({16'd5000, 20'd300000, 20'd600000});
      for (int i = 0; i < 10; i++) pending_readings.push_back(rand_reading());
      wait_drained();
      // extremes of every coefficient
      for (int i = 0; i < 6; i++) write_cal(stc_reg_type'(i), '1);
      for (int i = 0; i < 4; i++) pending_readings.push_back(rand_reading());
      pending_readings.push_back('1);
      wait_drained();
      for (int i = 0; i < 6; i++) write_cal(stc_reg_type'(i), 48'h8000_8000_8000);
      for (int i = 0; i < 4; i++) pending_readings.push_back(rand_reading());
      wait_drained();
      for (int ph = 0; ph < 12; ph++) begin
         if (ph % 3 == 2)
            for (int i = 0; i < 6; i++)
               write_cal(stc_reg_type'(i), {16'($urandom), 32'($urandom)});
         else load_typical_cal();
         quiet_req = (ph == 5); quiet_rsp = (ph == 5);
         for (int i = 0; i < 160; i++) pending_readings.push_back(rand_reading());
         wait_drained();
      end
      if (n_errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
